// ===== rtl/core/srsd_pkg.sv =====
// ----------------------------------------------------------------------------
// srsd_pkg: shared types and constants of the scanline sprite decoder
// Beat types of both channels, the register file image, the span request
// passed from the parser to the clipper, and the raster size limit.
// ----------------------------------------------------------------------------
package srsd_pkg;

   // Largest raster side; wider or taller register values saturate here
   localparam int unsigned MAX_DIM = 1024;

   // Signed width of intermediate column positions (origin + offset + run)
   localparam int unsigned POS_W = 20;

   // Register indexes, decoded from paddr[3:2]
   localparam logic [1:0] REG_RASTER_WIDTH  = 2'd0;
   localparam logic [1:0] REG_RASTER_HEIGHT = 2'd1;
   localparam logic [1:0] REG_ANCHOR_LEFT   = 2'd2;
   localparam logic [1:0] REG_ANCHOR_ABOVE  = 2'd3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       shape_start;
   } req_type;

   typedef struct packed {
      logic [9:0] span_x;
      logic [9:0] span_y;
      logic [6:0] span_len;
      logic [7:0] pixel_value;
      logic       shape_done;
   } rsp_type;

   typedef struct packed {
      logic [10:0] raster_width;
      logic [10:0] raster_height;
      logic [15:0] anchor_left;
      logic [15:0] anchor_above;
   } cfg_type;

   // Unclipped span produced by the parser for one beat
   typedef struct packed {
      logic             emit;
      logic             done;
      logic [POS_W-1:0] x0;
      logic [16:0]      y;
      logic [6:0]       n;
      logic [7:0]       pixel;
   } span_req_type;

endpackage

// ===== rtl/core/srsd_csr.sv =====
// ----------------------------------------------------------------------------
// srsd_csr: configuration registers
// APB-style register file with raster size and anchor registers.
// ----------------------------------------------------------------------------
module srsd_csr
   import srsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] reg_index;
   logic       wr_en;

   assign reg_index = paddr[3:2];
   assign wr_en     = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   // Update the addressed register on a write access
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_RASTER_WIDTH:  cfg_in.raster_width  = pwdata[10:0];
            REG_RASTER_HEIGHT: cfg_in.raster_height = pwdata[10:0];
            REG_ANCHOR_LEFT:   cfg_in.anchor_left   = pwdata[15:0];
            REG_ANCHOR_ABOVE:  cfg_in.anchor_above  = pwdata[15:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      unique case (reg_index)
         REG_RASTER_WIDTH:  prdata = {21'd0, cfg_ff.raster_width};
         REG_RASTER_HEIGHT: prdata = {21'd0, cfg_ff.raster_height};
         REG_ANCHOR_LEFT:   prdata = {16'd0, cfg_ff.anchor_left};
         REG_ANCHOR_ABOVE:  prdata = {16'd0, cfg_ff.anchor_above};
         default:           prdata = '0;
      endcase
   end

endmodule

// ===== rtl/core/srsd_parse.sv =====
// ----------------------------------------------------------------------------
// srsd_parse: stream parser
// Walks the header, origin words and line body one byte per step and
// presents the unclipped span that the current byte writes.
// ----------------------------------------------------------------------------
module srsd_parse
   import srsd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_type      beat,
   input  cfg_type      cfg,
   output span_req_type span
);

   localparam logic [3:0] PH_HDR_LO  = 4'd0;
   localparam logic [3:0] PH_HDR_HI  = 4'd1;
   localparam logic [3:0] PH_X_LO    = 4'd2;
   localparam logic [3:0] PH_X_HI    = 4'd3;
   localparam logic [3:0] PH_Y_LO    = 4'd4;
   localparam logic [3:0] PH_Y_HI    = 4'd5;
   localparam logic [3:0] PH_RAW     = 4'd6;
   localparam logic [3:0] PH_COUNT   = 4'd7;
   localparam logic [3:0] PH_REPEAT  = 4'd8;
   localparam logic [3:0] PH_LITERAL = 4'd9;

   logic [3:0]  phase_ff,     phase_in;
   logic [7:0]  low_hold_ff,  low_hold_in;
   logic [14:0] remaining_ff, remaining_in;
   logic        encoded_ff,   encoded_in;
   logic [16:0] origin_x_ff,  origin_x_in;
   logic [16:0] origin_y_ff,  origin_y_in;
   logic [14:0] offset_ff,    offset_in;
   logic [6:0]  literal_ff,   literal_in;

   logic [3:0]  phase_cur;
   logic [7:0]  b;
   logic [15:0] word;
   logic [16:0] word_ext;
   logic [6:0]  run_clamped;
   logic [6:0]  step_len;
   logic [14:0] offset_sum;
   logic [14:0] rem_diff;
   logic [6:0]  lit_dec;

   assign b         = beat.in_byte;
   assign phase_cur = beat.shape_start ? PH_HDR_LO : phase_ff;
   assign word      = {b, low_hold_ff};
   assign word_ext  = {word[15], word};

   // Repeat runs stop at the end of the line
   assign run_clamped = ({8'd0, literal_ff} > remaining_ff) ? remaining_ff[6:0] : literal_ff;
   assign step_len    = (phase_cur == PH_REPEAT) ? run_clamped : 7'd1;
   assign offset_sum  = offset_ff + {8'd0, step_len};
   assign rem_diff    = remaining_ff - {8'd0, step_len};
   assign lit_dec     = literal_ff - 7'd1;

   // Span candidate for this byte, from the line state before the update
   always_comb begin
      span.emit  = (phase_cur == PH_RAW) || (phase_cur == PH_REPEAT) ||
                   (phase_cur == PH_LITERAL);
      span.done  = (phase_cur == PH_HDR_HI) && (word == 16'd0);
      span.x0    = {{(POS_W-17){origin_x_ff[16]}}, origin_x_ff} +
                   {{(POS_W-15){1'b0}}, offset_ff};
      span.y     = origin_y_ff;
      span.n     = step_len;
      span.pixel = b;
   end

   // Next parser state
   always_comb begin
      phase_in     = phase_cur;
      low_hold_in  = low_hold_ff;
      remaining_in = remaining_ff;
      encoded_in   = encoded_ff;
      origin_x_in  = origin_x_ff;
      origin_y_in  = origin_y_ff;
      offset_in    = offset_ff;
      literal_in   = literal_ff;
      unique case (phase_cur)
         PH_HDR_LO: begin
            low_hold_in = b;
            phase_in    = PH_HDR_HI;
         end
         PH_HDR_HI: begin
            if (word == 16'd0) begin
               phase_in = PH_HDR_LO;
            end else begin
               encoded_in   = word[0];
               remaining_in = word[15:1];
               phase_in     = PH_X_LO;
            end
         end
         PH_X_LO: begin
            low_hold_in = b;
            phase_in    = PH_X_HI;
         end
         PH_X_HI: begin
            origin_x_in = word_ext + {cfg.anchor_left[15], cfg.anchor_left};
            phase_in    = PH_Y_LO;
         end
         PH_Y_LO: begin
            low_hold_in = b;
            phase_in    = PH_Y_HI;
         end
         PH_Y_HI: begin
            origin_y_in = word_ext + {cfg.anchor_above[15], cfg.anchor_above};
            offset_in   = '0;
            literal_in  = '0;
            if (remaining_ff == 15'd0) begin
               phase_in = PH_HDR_LO;
            end else begin
               phase_in = encoded_ff ? PH_COUNT : PH_RAW;
            end
         end
         PH_RAW: begin
            offset_in    = offset_sum;
            remaining_in = rem_diff;
            phase_in     = (rem_diff == 15'd0) ? PH_HDR_LO : PH_RAW;
         end
         PH_COUNT: begin
            if (b[7:1] == 7'd0) begin
               phase_in = PH_HDR_LO;
            end else begin
               literal_in = b[7:1];
               phase_in   = b[0] ? PH_REPEAT : PH_LITERAL;
            end
         end
         PH_REPEAT: begin
            literal_in   = '0;
            offset_in    = offset_sum;
            remaining_in = rem_diff;
            phase_in     = (rem_diff == 15'd0) ? PH_HDR_LO : PH_COUNT;
         end
         PH_LITERAL: begin
            literal_in   = lit_dec;
            offset_in    = offset_sum;
            remaining_in = rem_diff;
            if (rem_diff == 15'd0) begin
               phase_in = PH_HDR_LO;
            end else begin
               phase_in = (lit_dec == 7'd0) ? PH_COUNT : PH_LITERAL;
            end
         end
         default: begin
            phase_in = PH_HDR_LO;
         end
      endcase
   end

   // Advance only when the beat is consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR_LO;
         low_hold_ff  <= '0;
         remaining_ff <= '0;
         encoded_ff   <= 1'b0;
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         offset_ff    <= '0;
         literal_ff   <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         low_hold_ff  <= low_hold_in;
         remaining_ff <= remaining_in;
         encoded_ff   <= encoded_in;
         origin_x_ff  <= origin_x_in;
         origin_y_ff  <= origin_y_in;
         offset_ff    <= offset_in;
         literal_ff   <= literal_in;
      end
   end

endmodule

// ===== rtl/core/srsd_clip.sv =====
// ----------------------------------------------------------------------------
// srsd_clip: raster clipper
// Cuts a span to the raster, drops spans outside it, and forms the
// result beat for spans and shape ends.
// ----------------------------------------------------------------------------
module srsd_clip
   import srsd_pkg::*;
(
   input  span_req_type span,
   input  cfg_type      cfg,
   output logic         hit,
   output rsp_type      rsp
);

   logic [POS_W-1:0]        dim_max;
   logic [POS_W-1:0]        w_raw;
   logic [POS_W-1:0]        h_raw;
   logic signed [POS_W-1:0] w;
   logic signed [POS_W-1:0] h;
   logic signed [POS_W-1:0] x0;
   logic signed [POS_W-1:0] x1;
   logic signed [POS_W-1:0] y;
   logic signed [POS_W-1:0] x0c;
   logic signed [POS_W-1:0] x1c;
   logic [POS_W-1:0]        len;
   logic                    row_ok;
   logic                    col_ok;

   // Saturate the raster size
   assign dim_max = POS_W'(MAX_DIM);
   assign w_raw   = {{(POS_W-11){1'b0}}, cfg.raster_width};
   assign h_raw   = {{(POS_W-11){1'b0}}, cfg.raster_height};
   assign w       = $signed((w_raw > dim_max) ? dim_max : w_raw);
   assign h       = $signed((h_raw > dim_max) ? dim_max : h_raw);

   // Clip both ends of the span
   assign x0     = $signed(span.x0);
   assign x1     = x0 + $signed({{(POS_W-7){1'b0}}, span.n});
   assign y      = $signed({{(POS_W-17){span.y[16]}}, span.y});
   assign x0c    = (x0 < 0) ? '0 : x0;
   assign x1c    = (x1 > w) ? w : x1;
   assign row_ok = (y >= 0) && (y < h);
   assign col_ok = x0c < x1c;
   assign len    = x1c - x0c;

   assign hit = span.done || (span.emit && row_ok && col_ok);

   always_comb begin
      if (span.done) begin
         rsp            = '0;
         rsp.shape_done = 1'b1;
      end else begin
         rsp.span_x      = x0c[9:0];
         rsp.span_y      = y[9:0];
         rsp.span_len    = len[6:0];
         rsp.pixel_value = span.pixel;
         rsp.shape_done  = 1'b0;
      end
   end

endmodule

// ===== rtl/core/scanline_rle_sprite_decoder.sv =====
// ----------------------------------------------------------------------------
// scanline_rle_sprite_decoder: run-length scanline sprite decoder
// Parses an encoded sprite byte stream and emits clipped horizontal spans.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one stream byte per beat (in_byte, shape_start). A beat
//   is taken when req_valid is high and req_stall is low.
//   rsp_* carries at most one span per input byte: clipped start column,
//   row, length and palette index, or a shape_done beat with all else zero
//   when a zero header ends the shape. Fully clipped spans send nothing.
//   The APB-style port (psel/penable/pwrite/paddr/pwdata) sets raster width,
//   raster height and the two anchors at byte addresses 0, 4, 8 and 12;
//   write it only while the stream is idle.
// Timing:
//   One byte per cycle while rsp_stall is low. A byte lands in the input
//   register, is parsed and clipped from there, and its span is registered
//   in the output register that drives rsp_*.
//   When rsp_stall holds the output register, the input register still
//   takes one more byte; after that req_stall rises until the span drains.
// Reset:
//   Synchronous reset empties both registers, clears the registers of the
//   configuration port and puts the parser at the start of a header.
// ----------------------------------------------------------------------------
module scanline_rle_sprite_decoder
   import srsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type      cfg;
   span_req_type span;
   rsp_type      clip_rsp;
   logic         clip_hit;

   logic         in_valid_ff, in_valid_in;
   req_type      in_data_ff,  in_data_in;
   logic         out_valid_ff, out_valid_in;
   rsp_type      out_data_ff,  out_data_in;
   logic         advance;
   logic         accept;

   srsd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   srsd_parse u_parse (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .beat  (in_data_ff),
      .cfg   (cfg),
      .span  (span)
   );

   srsd_clip u_clip (
      .span (span),
      .cfg  (cfg),
      .hit  (clip_hit),
      .rsp  (clip_rsp)
   );

   // Move the held beat on when the output register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // Input register
   always_comb begin
      in_data_in = in_data_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Output register
   always_comb begin
      out_data_in = out_data_ff;
      if (advance) begin
         out_valid_in = clip_hit;
         out_data_in  = clip_rsp;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== rtl/core/srsd_check.sv =====
// ----------------------------------------------------------------------------
// srsd_check: port checker for the scanline sprite decoder
// Watches the result channel and reset behavior at the top-level ports.
// ----------------------------------------------------------------------------
module srsd_check
   import srsd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input req_type     req_data,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input rsp_type     rsp_data,
   input logic        psel,
   input logic        penable,
   input logic        pwrite,
   input logic [3:0]  paddr,
   input logic [31:0] pwdata,
   input logic [31:0] prdata,
   input logic        pready
);

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // Come out of reset with no result pending
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Shape end beats carry a zero length, span beats are never empty
   a_done_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.shape_done == (rsp_data.span_len == 7'd0)))
      else $error("span length and shape end disagree");

   // Spans stay inside the largest raster
   a_span_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.shape_done |->
         ({2'b00, rsp_data.span_x} + {5'd0, rsp_data.span_len}) <= 12'(MAX_DIM))
      else $error("span runs past the raster edge");

endmodule

bind scanline_rle_sprite_decoder srsd_check u_srsd_check (.*);
